[rtl/core/pcpfl_pkg.sv]
// ----------------------------------------------------------------------------
// pcpfl_pkg
// Shared constants for the per-cpu page free list allocator.
// ----------------------------------------------------------------------------
package pcpfl_pkg;

   localparam int ADDR_W     = 32;
   localparam int PAGE_SHIFT = 12;
   localparam int PAGE_W     = 20;
   localparam int TOP_W      = 21;
   localparam int LIMIT_W    = 11;
   localparam int CPU_ID_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 21;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 40;

   // widened cpu value for the modulo reduction
   localparam int CPU_RED_W  = 7;

   localparam logic [PAGE_W-1:0]  BASE_RESET  = 20'd524288;
   localparam logic [TOP_W-1:0]   TOP_RESET   = 21'd557056;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd64;

   localparam logic CMD_FREE  = 1'b0;
   localparam logic CMD_ALLOC = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_PAGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_ADR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_PAGE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_PAGE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BORROW_LIMIT = 2'd2;

endpackage

[rtl/core/pcpfl_link_ram.sv]
// ----------------------------------------------------------------------------
// pcpfl_link_ram
// Next-link table, one entry per page slot, one write and one registered read.
// ----------------------------------------------------------------------------
module pcpfl_link_ram #(
   parameter int DEPTH  = 32768,
   parameter int DATA_W = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data_ff
);

   logic [DATA_W-1:0] link_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= link_mem[rd_addr];
      end
   end

endmodule

[rtl/core/per_cpu_page_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_allocator
// Per-cpu LIFO page free lists with stealing on an empty allocate.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request: tuser is the command (free or allocate),
//   tdata holds cpu_id and the page address. rsp_* returns one response per
//   request: tuser is the status, tdata the allocated page address.
//   csr_* writes base_page, top_page and borrow_limit; the user must write
//   them only while the block idles, which the block leaves unchecked.
// Flow:
//   one request at a time; req_tready is high only in the idle state. a
//   free goes decode, done; an allocate from a non-empty list goes decode,
//   alloc, pop, done. an empty list first steals pages: each page takes a
//   link ram read, then the head swap, and each skipped cpu is passed over
//   in S_STEAL. the registered link ram read is why read and swap are apart.
// Reset:
//   all lists empty, registers at their reset values; no clearing pass.
// Stall:
//   the response sits in an output register until rsp_tready; a finished
//   request waits in S_DONE, and the next request is taken once it is loaded.
// ----------------------------------------------------------------------------
module per_cpu_page_free_list_allocator
   #(
   parameter int NUM_PAGES = 32768,
   parameter int NUM_CPUS  = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [pcpfl_pkg::REQ_DATA_W-1:0]   req_tdata,   // cpu_id, address
   input  logic                               req_tuser,   // command
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pcpfl_pkg::ADDR_W-1:0]       rsp_tdata,   // page_address
   output logic [pcpfl_pkg::STATUS_W-1:0]     rsp_tuser,   // status
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pcpfl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pcpfl_pkg::CSR_DATA_W-1:0]   csr_data
);

   import pcpfl_pkg::*;

   localparam int RA_W  = $clog2(NUM_PAGES);
   localparam int SLOT_W = $clog2(NUM_PAGES + 1);
   localparam int CPU_W = $clog2(NUM_CPUS);
   localparam int OTH_W = $clog2(NUM_CPUS + 1);
   localparam logic [SLOT_W-1:0] NULL_SLOT = SLOT_W'(NUM_PAGES);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_DECODE = 7'b0000010,
      S_ALLOC  = 7'b0000100,
      S_POP    = 7'b0001000,
      S_STEAL  = 7'b0010000,
      S_LINK   = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [PAGE_W-1:0]  base_ff;
   logic [TOP_W-1:0]   top_ff;
   logic [LIMIT_W-1:0] limit_ff;

   logic               cmd_ff;
   logic [CPU_W-1:0]   cpu_ff, cpu_in;
   logic [ADDR_W-1:0]  addr_ff;
   logic               stolen_ff, stolen_in;
   logic [OTH_W-1:0]   other_ff, other_in;
   logic [LIMIT_W-1:0] remain_ff, remain_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [ADDR_W-1:0]  res_addr_ff, res_addr_in;

   logic               rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ADDR_W-1:0]  rsp_addr_ff;

   logic [SLOT_W-1:0]  head_ff [NUM_CPUS];
   logic [SLOT_W-1:0]  head_in [NUM_CPUS];

   logic [CPU_RED_W-1:0] cpu_red;
   logic [CPU_W-1:0]   hd_idx;
   logic [CPU_W-1:0]   oth_idx;
   logic [SLOT_W-1:0]  hd_rd;
   logic               hd_null;
   logic               rsp_free;

   logic [PAGE_W-1:0]  page;
   logic [PAGE_W-1:0]  page_diff;
   logic               free_ok;
   logic [PAGE_W-1:0]  addr_sum;

   logic               ram_wr_en;
   logic [RA_W-1:0]    ram_wr_addr;
   logic [SLOT_W-1:0]  ram_wr_data;
   logic               ram_rd_en;
   logic [RA_W-1:0]    ram_rd_addr;
   logic [SLOT_W-1:0]  ram_rd_data;

   pcpfl_link_ram #(
      .DEPTH  (NUM_PAGES),
      .DATA_W (SLOT_W)
   ) u_link_ram (
      .clock      (clock),
      .wr_en      (ram_wr_en),
      .wr_addr    (ram_wr_addr),
      .wr_data    (ram_wr_data),
      .rd_en      (ram_rd_en),
      .rd_addr    (ram_rd_addr),
      .rd_data_ff (ram_rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // cpu_id modulo NUM_CPUS by repeated subtract, three bits need at most four
   always_comb begin
      cpu_red = CPU_RED_W'(req_tdata[CPU_ID_W-1:0]);
      for (int i = 0; i < 4; i++) begin
         if (cpu_red >= CPU_RED_W'(NUM_CPUS)) begin
            cpu_red = cpu_red - CPU_RED_W'(NUM_CPUS);
         end
      end
      cpu_in = cpu_red[CPU_W-1:0];
   end

   assign oth_idx = other_ff[CPU_W-1:0];
   assign hd_idx  = (state_ff == S_STEAL) ? oth_idx : cpu_ff;
   assign hd_rd   = head_ff[hd_idx];
   assign hd_null = (hd_rd == NULL_SLOT);

   // free address check
   assign page      = addr_ff[ADDR_W-1:PAGE_SHIFT];
   assign page_diff = page - base_ff;
   assign free_ok   = (addr_ff[PAGE_SHIFT-1:0] == '0)
                    && (page >= base_ff)
                    && ({1'b0, page} < top_ff)
                    && ({1'b0, page_diff} < TOP_W'(NUM_PAGES));

   assign addr_sum = base_ff + PAGE_W'(slot_ff);

   always_comb begin
      state_in      = state_ff;
      stolen_in     = stolen_ff;
      other_in      = other_ff;
      remain_in     = remain_ff;
      slot_in       = slot_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      head_in       = head_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = slot_ff[RA_W-1:0];
      ram_wr_data   = hd_rd;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = hd_rd[RA_W-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_addr_in = '0;
            stolen_in   = 1'b0;
            if (cmd_ff == CMD_FREE) begin
               state_in = S_DONE;
               if (free_ok) begin
                  ram_wr_en       = 1'b1;
                  ram_wr_addr     = page_diff[RA_W-1:0];
                  head_in[cpu_ff] = SLOT_W'({1'b0, page_diff});
                  res_status_in   = ST_OK;
               end else begin
                  res_status_in   = ST_BAD_ADR;
               end
            end else begin
               state_in = S_ALLOC;
            end
         end
         S_ALLOC: begin
            if (!hd_null) begin
               ram_rd_en = 1'b1;
               slot_in   = hd_rd;
               state_in  = S_POP;
            end else if (!stolen_ff && (limit_ff != '0)) begin
               stolen_in = 1'b1;
               other_in  = '0;
               remain_in = limit_ff;
               state_in  = S_STEAL;
            end else begin
               res_status_in = ST_NO_PAGE;
               res_addr_in   = '0;
               state_in      = S_DONE;
            end
         end
         S_POP: begin
            head_in[cpu_ff] = ram_rd_data;
            res_status_in   = ST_OK;
            res_addr_in     = {addr_sum, {PAGE_SHIFT{1'b0}}};
            state_in        = S_DONE;
         end
         S_STEAL: begin
            priority if ((remain_ff == '0) || (other_ff == OTH_W'(NUM_CPUS))) begin
               state_in = S_ALLOC;
            end else if ((oth_idx == cpu_ff) || hd_null) begin
               other_in = other_ff + 1'b1;
            end else begin
               ram_rd_en = 1'b1;
               slot_in   = hd_rd;
               state_in  = S_LINK;
            end
         end
         S_LINK: begin
            // pop from the other list, push onto our own
            head_in[oth_idx] = ram_rd_data;
            ram_wr_en        = 1'b1;
            head_in[cpu_ff]  = slot_ff;
            remain_in        = remain_ff - 1'b1;
            state_in         = S_STEAL;
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         base_ff      <= BASE_RESET;
         top_ff       <= TOP_RESET;
         limit_ff     <= LIMIT_RESET;
         stolen_ff    <= 1'b0;
         other_ff     <= '0;
         remain_ff    <= '0;
         for (int i = 0; i < NUM_CPUS; i++) begin
            head_ff[i] <= NULL_SLOT;
         end
      end else begin
         state_ff  <= state_in;
         stolen_ff <= stolen_in;
         other_ff  <= other_in;
         remain_ff <= remain_in;
         head_ff   <= head_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_BASE_PAGE:    base_ff  <= csr_data[PAGE_W-1:0];
               CSR_TOP_PAGE:     top_ff   <= csr_data[TOP_W-1:0];
               CSR_BORROW_LIMIT: limit_ff <= csr_data[LIMIT_W-1:0];
               default: ;
            endcase
         end
         if ((state_ff == S_DONE) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff       <= slot_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      if (req_tvalid && req_tready) begin
         cmd_ff  <= req_tuser;
         cpu_ff  <= cpu_in;
         addr_ff <= req_tdata[CPU_ID_W +: ADDR_W];
      end
      if ((state_ff == S_DONE) && rsp_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_addr_ff   <= res_addr_ff;
      end
   end

endmodule
